@@ hdl/acs_pkg.sv @@
// Shared constants for the alpha channel contrast stretch block.
`default_nettype none

package acs_pkg;

   // Pixel store geometry
   localparam int PIXEL_COUNT = 65536;
   localparam int PIX_AW      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int PIX_W       = 32;

   // Field widths
   localparam int INDEX_W = 16;
   localparam int CHAN_W  = 8;

   // Stream widths
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   // One quotient bit per divider step
   localparam int DIV_STEPS = CHAN_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   // Operation codes carried in tuser bit 0
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

endpackage

`default_nettype wire

@@ hdl/acs_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none

module acs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic                                  re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                      wdata,
   output logic      [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/alpha_channel_contrast_stretch.sv @@
// Top level of the alpha channel contrast stretch block.
//
//   channel | direction | tdata (low bit up)                         | tuser / tlast
//   --------+-----------+--------------------------------------------+---------------------------
//   req_    | in        | pixel_index[15:0] red green blue alpha     | [0] op, [1] first_pixel
//   rsp_    | out       | red green blue alpha                       | none
//
// A load is done in the accept cycle: the pixel is written into the pixel store
// and the alpha bounds are updated. A read passes through the memory read in the
// accept cycle, a setup state, eight steps of the restoring divider (one quotient
// bit each) when the alpha needs division, and a done state that moves the result
// into the output register. Reset is synchronous; it restores the alpha bounds
// (low 255, high 0) and the control state. The pixel store is not cleared. One
// item is in work at a time; a finished result waits in the output register,
// and further loads are taken while it waits. A new result holds until the
// output register is free.
`default_nettype none

module alpha_channel_contrast_stretch
   import acs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // pixel_index[15:0], red_in[23:16], green_in[31:24], blue_in[39:32], alpha_in[47:40]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op[0], first_pixel[1]
   input  wire logic [REQ_USER_W-1:0] req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   // Sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RDATA = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CHAN_W-1:0] low_ff, low_in;
   logic [CHAN_W-1:0] high_ff, high_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Result under construction
   logic [3*CHAN_W-1:0] res_rgb_ff, res_rgb_in;
   logic [CHAN_W-1:0]   res_alpha_ff, res_alpha_in;

   // Divider: partial remainder, dividend low byte that turns into the quotient
   logic [CHAN_W-1:0] rem_ff, rem_in;
   logic [CHAN_W-1:0] quo_ff, quo_in;
   logic [CHAN_W-1:0] range_ff, range_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;

   // Request fields
   logic              req_op;
   logic              req_first;
   logic [INDEX_W-1:0] req_index;
   logic [CHAN_W-1:0] req_red, req_green, req_blue, req_alpha;
   logic [31:0]       index_wide;
   logic              index_ok;
   logic              accept;

   // Store port
   logic              ram_we, ram_re;
   logic [PIX_AW-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_wdata, ram_rdata;

   // Stretch arithmetic
   logic [CHAN_W-1:0]   st_alpha;
   logic [CHAN_W-1:0]   st_diff;
   logic [2*CHAN_W-1:0] st_num;
   logic [CHAN_W:0]     div_trial;
   logic                div_bit;
   logic                out_free;

   assign req_op    = req_tuser[0];
   assign req_first = req_tuser[1];
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_red   = req_tdata[INDEX_W +: CHAN_W];
   assign req_green = req_tdata[INDEX_W+CHAN_W +: CHAN_W];
   assign req_blue  = req_tdata[INDEX_W+2*CHAN_W +: CHAN_W];
   assign req_alpha = req_tdata[INDEX_W+3*CHAN_W +: CHAN_W];

   assign index_wide = 32'(req_index);
   assign index_ok   = (index_wide < 32'(PIXEL_COUNT));

   // Take beats only in idle, never while reset is asserted
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   // Pixel store access happens only in the accept cycle: one item at a time
   // means a write and a later read of the same entry never overlap.
   assign ram_addr  = PIX_AW'(req_index);
   assign ram_we    = accept && (req_op == OP_LOAD) && index_ok;
   assign ram_re    = accept && (req_op == OP_READ) && index_ok;
   assign ram_wdata = {req_alpha, req_blue, req_green, req_red};

   acs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PIXEL_COUNT)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // (a - low) * 255 as (d << 8) - d
   assign st_alpha = ram_rdata[PIX_W-1 -: CHAN_W];
   assign st_diff  = st_alpha - low_ff;
   assign st_num   = {st_diff, CHAN_W'(0)} - {CHAN_W'(0), st_diff};

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, quo_ff[CHAN_W-1]};
   assign div_bit   = (div_trial >= {1'b0, range_ff});

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_rgb_in   = res_rgb_ff;
      res_alpha_in = res_alpha_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      range_in     = range_ff;
      cnt_in       = cnt_ff;

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  // Update the alpha bounds; an index beyond the store is ignored
                  if (index_ok) begin
                     if (req_first) begin
                        low_in  = req_alpha;
                        high_in = req_alpha;
                     end else begin
                        if (req_alpha < low_ff) begin
                           low_in = req_alpha;
                        end
                        if (req_alpha > high_ff) begin
                           high_in = req_alpha;
                        end
                     end
                  end
               end else if (index_ok) begin
                  state_in = ST_RDATA;
               end else begin
                  // Read beyond the store answers with an all-zero beat
                  res_rgb_in   = '0;
                  res_alpha_in = '0;
                  state_in     = ST_DONE;
               end
            end
         end

         ST_RDATA: begin
            res_rgb_in = ram_rdata[3*CHAN_W-1:0];
            if (high_ff <= low_ff) begin
               // Empty, flat or inverted range: pass alpha through
               res_alpha_in = st_alpha;
               state_in     = ST_DONE;
            end else if (st_alpha <= low_ff) begin
               res_alpha_in = '0;
               state_in     = ST_DONE;
            end else if (st_alpha >= high_ff) begin
               res_alpha_in = CHAN_MAX;
               state_in     = ST_DONE;
            end else begin
               // Quotient fits in one byte, so the high dividend byte is
               // already below the range and seeds the remainder.
               rem_in   = st_num[2*CHAN_W-1 -: CHAN_W];
               quo_in   = st_num[CHAN_W-1:0];
               range_in = high_ff - low_ff;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            rem_in = div_bit ? CHAN_W'(div_trial - {1'b0, range_ff})
                             : div_trial[CHAN_W-1:0];
            quo_in = {quo_ff[CHAN_W-2:0], div_bit};
            cnt_in = cnt_ff + DIV_CW'(1);
            if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               res_alpha_in = {quo_ff[CHAN_W-2:0], div_bit};
               state_in     = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_alpha_ff, res_rgb_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= CHAN_MAX;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      res_rgb_ff   <= res_rgb_in;
      res_alpha_ff <= res_alpha_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      range_ff     <= range_in;
      cnt_ff       <= cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/acs_checker.sv @@
// Port-level checker for the alpha channel contrast stretch block, with its bind.
`default_nettype none

module acs_checker
   import acs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_USER_W-1:0] req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled output beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output beat changed while stalled");

   // A load never raises a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == OP_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("load produced a result");

   // A read keeps the input side closed while it is worked on
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == OP_READ) |=> !req_tready)
      else $error("input taken while a read is in work");

   // A new result only appears after a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a read in work");

endmodule

bind alpha_channel_contrast_stretch acs_checker u_acs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the alpha channel contrast stretch block.
`default_nettype none

module testbench;
   import acs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 40;

   // One pixel as it sits in the store and on rsp_tdata: red in the low byte
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgba_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // pixel_index, red_in, green_in, blue_in, alpha_in (low bit up)
   logic [REQ_DATA_W-1:0] req_tdata;
   // op, first_pixel (low bit up)
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // red_out, green_out, blue_out, alpha_out (low bit up)
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Mirror of the block: pixel store, alpha bounds, and which entries hold data
   rgba_type          image_mem [PIXEL_COUNT];
   bit                is_loaded [PIXEL_COUNT];
   int                loaded_idx [$];
   logic [CHAN_W-1:0] alpha_floor;
   logic [CHAN_W-1:0] alpha_ceil;

   rgba_type expected_pixels [$];
   int    mismatch_count;
   int    cycle_count = 0;
   int    beats_sent;
   int    req_idle_pct;
   int    rsp_stall_pct;
   int    hold_cycles_left;

   alpha_channel_contrast_stretch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Integer min-max stretch of one alpha sample against the current bounds
   function automatic logic [CHAN_W-1:0] normalize_height(input logic [CHAN_W-1:0] a);
      int span;
      if (alpha_ceil <= alpha_floor) return a;   // empty, inverted or flat range
      if (a <= alpha_floor) return '0;           // below the image: clamp low
      if (a >= alpha_ceil) return CHAN_MAX;      // above the image: clamp high
      span = int'(alpha_ceil) - int'(alpha_floor);
      return CHAN_W'(((int'(a) - int'(alpha_floor)) * 255) / span);
   endfunction

   // Advance the mirror by one accepted beat and queue the result it causes
   function automatic void apply_pixel_op(input logic op, input logic [INDEX_W-1:0] index,
                                          input logic first, input rgba_type pix);
      rgba_type word;
      if (op == OP_LOAD) begin
         if (int'(index) >= PIXEL_COUNT) return;   // out-of-range load is dropped
         if (!is_loaded[index]) begin
            is_loaded[index] = 1'b1;
            loaded_idx.push_back(int'(index));
         end
         image_mem[index] = pix;
         if (first) begin
            alpha_floor = pix.alpha;
            alpha_ceil  = pix.alpha;
         end else begin
            if (pix.alpha < alpha_floor) alpha_floor = pix.alpha;
            if (pix.alpha > alpha_ceil) alpha_ceil = pix.alpha;
         end
      end else if (int'(index) >= PIXEL_COUNT) begin
         expected_pixels.push_back('0);
      end else begin
         word = image_mem[index];
         word.alpha = normalize_height(word.alpha);
         expected_pixels.push_back(word);
      end
   endfunction

   function automatic rgba_type make_pixel(input int r, input int g, input int b, input int a);
      return rgba_type'({a[7:0], b[7:0], g[7:0], r[7:0]});
   endfunction

   function automatic rgba_type random_pixel();
      return rgba_type'($urandom);
   endfunction

   // Offer one beat after a random idle gap; hold it until the handshake
   task automatic send_pixel_beat(input logic op, input logic [INDEX_W-1:0] index,
                                  input logic first, input rgba_type pix);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pix.alpha, pix.blue, pix.green, pix.red, index};
      req_tuser  <= {first, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_pixel_op(op, index, first, pix);
      beats_sent++;
   endtask

   task automatic load_pixel(input logic [INDEX_W-1:0] index, input logic first,
                             input rgba_type pix);
      send_pixel_beat(OP_LOAD, index, first, pix);
   endtask

   // Read carries random junk in first_pixel and the channel fields
   task automatic read_pixel(input logic [INDEX_W-1:0] index);
      send_pixel_beat(OP_READ, index, 1'($urandom), random_pixel());
   endtask

   task automatic read_any_loaded();
      read_pixel(INDEX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]));
   endtask

   // Drop valid and hold until every queued result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // One image: a first pixel, more loads mostly in a window, then reads of it and older data
   task automatic send_image_burst();
      int                 n_loads;
      int                 n_reads;
      int                 a_lo;
      int                 a_hi;
      int                 shape;
      logic [INDEX_W-1:0] base;
      logic [INDEX_W-1:0] idx;
      int                 mine [$];
      rgba_type           pix;
      shape   = $urandom_range(0, 9);
      n_loads = $urandom_range(1, 8);
      n_reads = $urandom_range(1, 8);
      base    = INDEX_W'($urandom);
      a_lo    = $urandom_range(0, 255);
      a_hi    = $urandom_range(a_lo, 255);
      if (shape == 0) a_hi = a_lo;                 // flat image
      if (shape == 1) begin
         a_lo = 0;
         a_hi = 255;
      end
      for (int i = 0; i < n_loads; i++) begin
         idx = ($urandom_range(0, 19) == 0) ? INDEX_W'($urandom)
                                            : base + INDEX_W'($urandom_range(0, 15));
         pix = random_pixel();
         pix.alpha = CHAN_W'($urandom_range(a_lo, a_hi));
         load_pixel(idx, i == 0, pix);
         mine.push_back(int'(idx));
      end
      for (int i = 0; i < n_reads; i++) begin
         if ($urandom_range(0, 9) < 7) read_pixel(INDEX_W'(mine[$urandom_range(0, mine.size() - 1)]));
         else read_any_loaded();
      end
   endtask

   // Stray beats: loads with a random first flag, lone reads
   task automatic send_noise_beat();
      if ($urandom_range(0, 1) == 0) load_pixel(INDEX_W'($urandom), 1'($urandom), random_pixel());
      else read_any_loaded();
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_beats);
      int start;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      start = beats_sent;
      while (beats_sent - start < n_beats) begin
         if ($urandom_range(0, 99) < 85) send_image_burst();
         else send_noise_beat();
      end
      wait_for_results();
   endtask

   // Extremes, flat and all-255 images, clamping, range of one, junk on reads
   task automatic test_directed_cases();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      load_pixel(16'h0000, 1'b0, make_pixel(8'h12, 8'h34, 8'h56, 100));   // bounds meet at 100
      read_pixel(16'h0000);
      load_pixel(16'hFFFF, 1'b1, make_pixel(255, 255, 255, 255));        // all-255 image
      read_pixel(16'hFFFF);
      load_pixel(16'h0001, 1'b1, make_pixel(0, 0, 0, 10));
      load_pixel(16'h0002, 1'b0, make_pixel(8'h80, 8'h01, 8'hFE, 200));
      load_pixel(16'h0003, 1'b0, make_pixel(8'h7F, 8'hC3, 8'h3C, 77));
      read_pixel(16'h0001);
      read_pixel(16'h0002);
      read_pixel(16'h0003);
      read_pixel(16'h0000);
      load_pixel(16'h00FF, 1'b1, make_pixel(1, 2, 3, 150));             // new image 150..160
      load_pixel(16'hFF00, 1'b0, make_pixel(4, 5, 6, 160));
      read_pixel(16'h0001);                                             // left over, below
      read_pixel(16'hFFFF);                                             // left over, above
      read_pixel(16'hFF00);
      send_pixel_beat(OP_READ, 16'h00FF, 1'b1, make_pixel(255, 255, 255, 255));
      load_pixel(16'h5555, 1'b1, make_pixel(0, 0, 0, 0));
      load_pixel(16'hAAAA, 1'b0, make_pixel(255, 255, 255, 255));
      load_pixel(16'h1234, 1'b0, make_pixel(8'hAA, 8'h55, 8'h0F, 128));
      read_pixel(16'h1234);
      load_pixel(16'h4321, 1'b1, make_pixel(9, 8, 7, 0));               // range of one
      load_pixel(16'h4322, 1'b0, make_pixel(6, 5, 4, 1));
      read_pixel(16'h4321);
      read_pixel(16'h4322);
      wait_for_results();
   endtask

   task automatic test_streaming_no_idle();
      run_random_phase(0, 0, 400);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(45, 0, 400);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 45, 400);
   endtask

   task automatic test_both_sides_idle();
      run_random_phase(8, 8, 400);
   endtask

   // Hold the result side off for a long stretch while beats keep coming,
   // so the output register fills and the input stalls
   task automatic test_output_backpressure();
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      hold_cycles_left = 300;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0) load_pixel(INDEX_W'($urandom), 1'b0, random_pixel());
         else read_any_loaded();
      end
      wait_for_results();
   endtask

   // Main sequence
   initial begin
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      req_tuser        <= '0;
      mismatch_count   = 0;
      beats_sent       = 0;
      hold_cycles_left = 0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      alpha_floor      = CHAN_MAX;
      alpha_ceil       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_streaming_no_idle();
      test_output_backpressure();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_sides_idle();

      // Let the block settle past its longest read before judging
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Result side: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_left > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   function automatic void check_channel(input string name, input logic [CHAN_W-1:0] want,
                                         input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin
      rgba_type got;
      rgba_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rgba_type'(rsp_tdata);
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $realtime, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_channel("red", want.red, got.red);
            check_channel("green", want.green, got.green);
            check_channel("blue", want.blue, got.blue);
            check_channel("alpha", want.alpha, got.alpha);
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

`default_nettype wire

@@ alpha_channel_contrast_stretch.f @@
hdl/acs_pkg.sv
hdl/acs_ram.sv
hdl/alpha_channel_contrast_stretch.sv
hdl/acs_checker.sv
bench/testbench.sv
